@@ sv/sfp_pkg.sv @@
// Shared types and constants for the sensor frame packer.
`timescale 1ns / 1ps
package sfp_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAIN_WINDOW      = 3'd0,
    CFG_RAIN_EVENT_LIMIT = 3'd1,
    CFG_TILT_THRESHOLD   = 3'd2,
    CFG_TEMP_LIMIT       = 3'd3,
    CFG_LEVEL_LIMIT      = 3'd4
  } cfg_idx_e;

  localparam logic [15:0] RAIN_WINDOW_RST      = 16'd4500;
  localparam logic [15:0] RAIN_EVENT_LIMIT_RST = 16'd700;
  localparam logic [6:0]  TILT_THRESHOLD_RST   = 7'd15;
  localparam logic [15:0] TEMP_LIMIT_RST       = 16'd2000;
  localparam logic [10:0] LEVEL_LIMIT_RST      = 11'd15;

  localparam logic [7:0]  FRAME_HEADER = 8'hF3;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  // echo / 58 via reciprocal: floor(echo * 36157 / 2^21) is low by at most one
  localparam logic [15:0] DIV58_MUL   = 16'd36157;
  localparam int unsigned DIV58_SHIFT = 21;
  localparam logic [15:0] LEVEL_DIV   = 16'd58;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    BYTE_HEADER   = 3'd0,
    BYTE_ACCEL_HI = 3'd1,
    BYTE_ACCEL_LO = 3'd2,
    BYTE_TEMP_HI  = 3'd3,
    BYTE_TEMP_LO  = 3'd4,
    BYTE_LEVEL_HI = 3'd5,
    BYTE_LEVEL_LO = 3'd6
  } byte_sel_e;

  typedef struct packed {
    logic [15:0] accel_sample;
    logic [15:0] temp_sample;
    logic [15:0] echo_time;
    logic        light_bit;
    logic        humid_bit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       light_drive;
    logic       window_drive;
    logic       potable_valve;
    logic       rainwater_valve;
  } out_item_t;

  typedef struct packed {
    logic [15:0] rain_window;
    logic [15:0] rain_event_limit;
    logic [6:0]  tilt_threshold;
    logic [15:0] temp_limit;
    logic [10:0] level_limit;
  } cfg_t;

  // classified measurement handed from front to back
  typedef struct packed {
    logic [11:0] accel12;
    logic [11:0] temp12;
    logic [10:0] level;
    logic        light_bit;
    logic        humid_bit;
    logic        raining;
    logic        window_drive;
  } q_item_t;

endpackage

@@ sv/sfp_front.sv @@
// Front end: accepts measurements, runs the rain window logic and computes the level.
`timescale 1ns / 1ps
module sfp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sfp_pkg::cfg_t    cfg_i,
  input  logic             push_i,
  input  sfp_pkg::in_item_t in_item_i,
  output logic             full_o,
  input  logic             q_full_i,
  output logic             q_push_o,
  output sfp_pkg::q_item_t q_item_o
);

  logic [15:0] window_count_q, window_count_d;
  logic [15:0] event_count_q, event_count_d;
  logic        raining_q, raining_d;
  logic        s1_valid_q, s1_valid_d;
  logic [31:0] s1_prod_q;
  logic [15:0] s1_echo_q;
  sfp_pkg::q_item_t s1_item_q, s1_item_d;

  logic        accept;
  logic        s1_move;
  logic        window_end;
  logic [15:0] event_base;
  logic [10:0] q_est;
  logic [15:0] rem;
  logic [10:0] level;

  assign s1_move  = s1_valid_q && !q_full_i;
  assign full_o   = s1_valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = s1_move;

  // rain window bookkeeping for the accepted transaction
  always_comb begin
    window_end     = window_count_q > cfg_i.rain_window;
    raining_d      = raining_q;
    window_count_d = window_count_q;
    event_count_d  = event_count_q;
    event_base     = event_count_q;
    if (accept) begin
      if (window_end) begin
        raining_d      = event_count_q > cfg_i.rain_event_limit;
        window_count_d = '0;
        event_base     = '0;
      end else begin
        window_count_d = window_count_q + 16'd1;
      end
      event_count_d = event_base;
      if (in_item_i.accel_sample[10:4] > cfg_i.tilt_threshold
          && event_base != sfp_pkg::COUNT_MAX) begin
        event_count_d = event_base + 16'd1;
      end
    end
  end

  always_comb begin
    s1_item_d              = s1_item_q;
    s1_item_d.accel12      = in_item_i.accel_sample[15:4];
    s1_item_d.temp12       = in_item_i.temp_sample[15:4];
    s1_item_d.level        = '0;
    s1_item_d.light_bit    = in_item_i.light_bit;
    s1_item_d.humid_bit    = in_item_i.humid_bit;
    s1_item_d.raining      = raining_d;
    s1_item_d.window_drive = !(in_item_i.temp_sample > cfg_i.temp_limit);
  end

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_count_q <= '0;
      event_count_q  <= '0;
      raining_q      <= 1'b0;
      s1_valid_q     <= 1'b0;
    end else begin
      window_count_q <= window_count_d;
      event_count_q  <= event_count_d;
      raining_q      <= raining_d;
      s1_valid_q     <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= s1_item_d;
      s1_echo_q <= in_item_i.echo_time;
      s1_prod_q <= {16'd0, in_item_i.echo_time} * {16'd0, sfp_pkg::DIV58_MUL};
    end
  end

  // correct the reciprocal estimate by one remainder check
  always_comb begin
    q_est = s1_prod_q[sfp_pkg::DIV58_SHIFT +: 11];
    rem   = s1_echo_q - 16'({5'd0, q_est} * sfp_pkg::LEVEL_DIV);
    level = (rem >= sfp_pkg::LEVEL_DIV) ? q_est + 11'd1 : q_est;
  end

  always_comb begin
    q_item_o       = s1_item_q;
    q_item_o.level = level;
  end

endmodule

@@ sv/sfp_fifo.sv @@
// Short register queue between front and back.
`timescale 1ns / 1ps
module sfp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfp_pkg::q_item_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output sfp_pkg::q_item_t data_o
);

  sfp_pkg::q_item_t mem_q [sfp_pkg::FIFO_DEPTH];
  logic [sfp_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [sfp_pkg::FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [sfp_pkg::FIFO_CNT_W-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o  = count_q == sfp_pkg::FIFO_CNT_W'(sfp_pkg::FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ sv/sfp_back.sv @@
// Back end: derives valve drives and serializes the seven-byte frame.
`timescale 1ns / 1ps
module sfp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [10:0]       level_limit_i,
  input  logic              q_empty_i,
  input  sfp_pkg::q_item_t  q_item_i,
  output logic              q_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output sfp_pkg::out_item_t out_item_o
);

  logic              busy_q, busy_d;
  sfp_pkg::byte_sel_e idx_q, idx_d;
  sfp_pkg::q_item_t  cur_q;
  logic              potable_q, rainwater_q;
  logic              potable_d, rainwater_d;
  logic [10:0]       prev_level_q;
  logic              last, done, load;

  assign last    = idx_q == sfp_pkg::BYTE_LEVEL_LO;
  assign done    = busy_q && pop_i && last;
  assign load    = !q_empty_i && (!busy_q || done);
  assign q_pop_o = load;
  assign empty_o = !busy_q;

  // valves look at the level of the previous measurement
  always_comb begin
    potable_d   = 1'b1;
    rainwater_d = 1'b1;
    if (prev_level_q > level_limit_i) begin
      potable_d   = q_item_i.raining;
      rainwater_d = !q_item_i.raining;
    end
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = sfp_pkg::BYTE_HEADER;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (busy_q && pop_i) begin
      idx_d = sfp_pkg::byte_sel_e'(idx_q + 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      idx_q        <= sfp_pkg::BYTE_HEADER;
      prev_level_q <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      if (load) begin
        prev_level_q <= q_item_i.level;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q       <= q_item_i;
      potable_q   <= potable_d;
      rainwater_q <= rainwater_d;
    end
  end

  always_comb begin
    out_item_o.last_byte       = last;
    out_item_o.light_drive     = cur_q.light_bit;
    out_item_o.window_drive    = cur_q.window_drive;
    out_item_o.potable_valve   = potable_q;
    out_item_o.rainwater_valve = rainwater_q;
    unique case (idx_q)
      sfp_pkg::BYTE_HEADER:   out_item_o.frame_byte = sfp_pkg::FRAME_HEADER;
      sfp_pkg::BYTE_ACCEL_HI: out_item_o.frame_byte =
          {1'b0, !cur_q.light_bit, !cur_q.humid_bit, cur_q.accel12[11:7]};
      sfp_pkg::BYTE_ACCEL_LO: out_item_o.frame_byte = {1'b0, cur_q.accel12[6:0]};
      sfp_pkg::BYTE_TEMP_HI:  out_item_o.frame_byte =
          {1'b0, !cur_q.raining, 1'b0, cur_q.temp12[11:7]};
      sfp_pkg::BYTE_TEMP_LO:  out_item_o.frame_byte = {1'b0, cur_q.temp12[6:0]};
      sfp_pkg::BYTE_LEVEL_HI: out_item_o.frame_byte = {4'd0, cur_q.level[10:7]};
      sfp_pkg::BYTE_LEVEL_LO: out_item_o.frame_byte = {1'b0, cur_q.level[6:0]};
      default:                out_item_o.frame_byte = sfp_pkg::FRAME_HEADER;
    endcase
  end

endmodule

@@ sv/sensor_frame_packer_with_rain_detect.sv @@
// Top level: configuration registers, front end, queue and frame serializer.
//
//  channel   ports                                      transaction when
//  input     push, full, in_item_i                      push && !full
//  result    empty, pop, out_item_o                     pop && !empty
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,     cfg_valid_i && cfg_ready_o
//            cfg_data_i
//
// Each measurement yields seven result bytes, one per cycle while pop is held high; the
// byte serializer sets the sustained measurement rate.
// First byte reaches the result ports through the queue write and then the load.
// A 4-entry queue lets the front keep accepting while the serializer stalls on pop.
// Reset clears counters, raining flag, previous level and all valid state; config
// registers return to their defaults. Config is always ready.
`timescale 1ns / 1ps
module sensor_frame_packer_with_rain_detect (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  sfp_pkg::in_item_t                    in_item_i,
  output logic                                 empty,
  input  logic                                 pop,
  output sfp_pkg::out_item_t                   out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sfp_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  sfp_pkg::cfg_t    cfg_q, cfg_d;
  logic             q_push, q_full, q_pop, q_empty;
  sfp_pkg::q_item_t q_wr_item, q_rd_item;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (sfp_pkg::cfg_idx_e'(cfg_index_i))
        sfp_pkg::CFG_RAIN_WINDOW:      cfg_d.rain_window      = cfg_data_i;
        sfp_pkg::CFG_RAIN_EVENT_LIMIT: cfg_d.rain_event_limit = cfg_data_i;
        sfp_pkg::CFG_TILT_THRESHOLD:   cfg_d.tilt_threshold   = cfg_data_i[6:0];
        sfp_pkg::CFG_TEMP_LIMIT:       cfg_d.temp_limit       = cfg_data_i;
        sfp_pkg::CFG_LEVEL_LIMIT:      cfg_d.level_limit      = cfg_data_i[10:0];
        default:                       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rain_window      <= sfp_pkg::RAIN_WINDOW_RST;
      cfg_q.rain_event_limit <= sfp_pkg::RAIN_EVENT_LIMIT_RST;
      cfg_q.tilt_threshold   <= sfp_pkg::TILT_THRESHOLD_RST;
      cfg_q.temp_limit       <= sfp_pkg::TEMP_LIMIT_RST;
      cfg_q.level_limit      <= sfp_pkg::LEVEL_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sfp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push_i    (push),
    .in_item_i (in_item_i),
    .full_o    (full),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_item_o  (q_wr_item)
  );

  sfp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rd_item)
  );

  sfp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .level_limit_i (cfg_q.level_limit),
    .q_empty_i     (q_empty),
    .q_item_i      (q_rd_item),
    .q_pop_o       (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .out_item_o    (out_item_o)
  );

  // front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("queue overflow");

  // back never loads from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("queue underflow");

  // the byte after a frame's last byte starts a new frame with the header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (pop && !empty && out_item_o.last_byte)
      |=> (empty || out_item_o.frame_byte == sfp_pkg::FRAME_HEADER))
    else $error("frame does not start with header");

  // only the header byte has its top bit set, so the last byte never has it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (!empty && out_item_o.frame_byte[7]) |-> !out_item_o.last_byte)
    else $error("payload byte with top bit set");

endmodule

@@ verif/sensor_frame_packer_with_rain_detect_tb.sv @@
// Testbench for the sensor frame packer: scoreboard against a behavioral predictor.
`timescale 1ns / 1ps
module sensor_frame_packer_with_rain_detect_tb;

  localparam int unsigned NUM_DIR        = 16;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  // one directed row; bytes/drives are used only where typed is set
  typedef struct packed {
    sfp_pkg::in_item_t meas;
    logic              typed;
    logic [55:0]       bytes;
    logic [3:0]        drives;  // light, window, potable, rainwater
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  sfp_pkg::in_item_t  in_item_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  sfp_pkg::out_item_t out_item_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [sfp_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [sfp_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // predictor state and register copy
  sfp_pkg::cfg_t reg_model;
  logic [15:0]   win_cnt;
  logic [15:0]   evt_cnt;
  logic          rain_flag;
  logic [10:0]   last_level;

  sfp_pkg::out_item_t frame_q [$];
  dir_row_t    dir_tab [NUM_DIR];
  int unsigned mism_cnt = 0;
  int unsigned stall_cycles = 0;
  int unsigned rx_stall = 0;
  int unsigned cyc = 0;
  bit          rx_free = 1'b0;
  bit          long_run = 1'b0;

  sensor_frame_packer_with_rain_detect uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sfp_pkg::in_item_t rand_meas();
    sfp_pkg::in_item_t m;
    int                e;
    m.accel_sample = 16'($urandom);
    m.temp_sample  = 16'($urandom);
    m.echo_time    = 16'($urandom);
    m.light_bit    = 1'($urandom);
    m.humid_bit    = 1'($urandom);
    // steer fields onto their decision boundaries part of the time
    if ($urandom_range(0, 3) == 0)
      m.accel_sample[10:4] = reg_model.tilt_threshold + 7'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0)
      m.temp_sample = reg_model.temp_limit + 16'($urandom_range(0, 1));
    if ($urandom_range(0, 2) == 0) begin
      e = 58 * $urandom_range(0, 1129) + $urandom_range(0, 2) - 1;
      if (e < 0) e = 0;
      m.echo_time = 16'(e);
    end
    if (long_run) m.accel_sample[4] = 1'b1;  // every item is a tilt event
    return m;
  endfunction

  task automatic predict_frame(input sfp_pkg::in_item_t m, input logic typed,
                               input logic [55:0] t_bytes, input logic [3:0] t_drv);
    sfp_pkg::out_item_t r;
    logic [11:0]     a12;
    logic [11:0]     t12;
    logic [10:0]     lvl;
    logic [0:6][7:0] fb;
    logic            l_drv;
    logic            w_drv;
    logic            p_v;
    logic            r_v;
    if (win_cnt > reg_model.rain_window) begin
      rain_flag = evt_cnt > reg_model.rain_event_limit;
      win_cnt   = '0;
      evt_cnt   = '0;
    end else begin
      win_cnt = win_cnt + 16'd1;
    end
    l_drv = m.light_bit;
    w_drv = !(m.temp_sample > reg_model.temp_limit);
    // valves act on the level of the previous measurement
    if (last_level > reg_model.level_limit) begin
      p_v = rain_flag;
      r_v = !rain_flag;
    end else begin
      p_v = 1'b1;
      r_v = 1'b1;
    end
    a12 = m.accel_sample[15:4];
    t12 = m.temp_sample[15:4];
    lvl = 11'(m.echo_time / sfp_pkg::LEVEL_DIV);
    fb[0] = sfp_pkg::FRAME_HEADER;
    fb[1] = {1'b0, !m.light_bit, !m.humid_bit, a12[11:7]};
    fb[2] = {1'b0, a12[6:0]};
    fb[3] = {1'b0, !rain_flag, 1'b0, t12[11:7]};
    fb[4] = {1'b0, t12[6:0]};
    fb[5] = {4'b0, lvl[10:7]};
    fb[6] = {1'b0, lvl[6:0]};
    if (a12[6:0] > reg_model.tilt_threshold && evt_cnt != sfp_pkg::COUNT_MAX)
      evt_cnt = evt_cnt + 16'd1;
    last_level = lvl;
    if (typed) begin
      fb = t_bytes;
      {l_drv, w_drv, p_v, r_v} = t_drv;
    end
    for (int k = 0; k < 7; k++) begin
      r.frame_byte      = fb[k];
      r.last_byte       = (k == 6);
      r.light_drive     = l_drv;
      r.window_drive    = w_drv;
      r.potable_valve   = p_v;
      r.rainwater_valve = r_v;
      frame_q.push_back(r);
    end
  endtask

  // hold push until the transaction is taken, then record its frame
  task automatic send_meas(input sfp_pkg::in_item_t m, input logic typed,
                           input logic [55:0] t_bytes, input logic [3:0] t_drv);
    push      <= 1'b1;
    in_item_i <= m;
    do @(posedge clk_i); while (full);
    predict_frame(m, typed, t_bytes, t_drv);
  endtask

  task automatic wait_drained();
    while (frame_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_batch(input int unsigned n, input bit use_tab, input bit drain_mid);
    int unsigned g;
    bit          drain;
    for (int unsigned i = 0; i < n; i++) begin
      if (use_tab)
        send_meas(dir_tab[i].meas, dir_tab[i].typed, dir_tab[i].bytes, dir_tab[i].drives);
      else
        send_meas(rand_meas(), 1'b0, '0, '0);
      g     = (long_run || (i % 40) < 10) ? 0 : pick_gap();
      drain = drain_mid && (i == n / 2);
      if (g != 0 || drain || i == n - 1) push <= 1'b0;
      repeat (g) @(posedge clk_i);
      if (drain) wait_drained();
    end
  endtask

  task automatic program_regs(input logic [15:0] win, input logic [15:0] evl,
                              input logic [6:0] tilt, input logic [15:0] tlim,
                              input logic [10:0] llim);
    sfp_pkg::cfg_idx_e idx;
    logic [15:0]       v;
    idx = sfp_pkg::CFG_RAIN_WINDOW;
    cfg_valid_i <= 1'b1;
    repeat (5) begin
      case (idx)
        sfp_pkg::CFG_RAIN_WINDOW: begin
          v = win;
          reg_model.rain_window = win;
        end
        sfp_pkg::CFG_RAIN_EVENT_LIMIT: begin
          v = evl;
          reg_model.rain_event_limit = evl;
        end
        sfp_pkg::CFG_TILT_THRESHOLD: begin
          v = {9'b0, tilt};
          reg_model.tilt_threshold = tilt;
        end
        sfp_pkg::CFG_TEMP_LIMIT: begin
          v = tlim;
          reg_model.temp_limit = tlim;
        end
        default: begin
          v = {5'b0, llim};
          reg_model.level_limit = llim;
        end
      endcase
      cfg_index_i <= idx;
      cfg_data_i  <= v;
      do @(posedge clk_i); while (!cfg_ready_o);
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic chk(input string fld, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mism_cnt++;
      $error("%s: expected %0h, got %0h", fld, want, got);
    end
  endtask

  // result side: random stalls with periodic free-flowing stretches
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (rx_stall != 0) begin
      pop      <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      pop <= 1'b1;
      if (!rx_free && cyc[8:7] != 2'd0 && $urandom_range(0, 3) == 0)
        rx_stall <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    sfp_pkg::out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (frame_q.size() == 0) begin
        mism_cnt++;
        $error("frame byte %0h arrived with nothing pending", out_item_o.frame_byte);
      end else begin
        want = frame_q.pop_front();
        chk("frame_byte", want.frame_byte, out_item_o.frame_byte);
        chk("last_byte", 8'(want.last_byte), 8'(out_item_o.last_byte));
        chk("light_drive", 8'(want.light_drive), 8'(out_item_o.light_drive));
        chk("window_drive", 8'(want.window_drive), 8'(out_item_o.window_drive));
        chk("potable_valve", 8'(want.potable_valve), 8'(out_item_o.potable_valve));
        chk("rainwater_valve", 8'(want.rainwater_valve), 8'(out_item_o.rainwater_valve));
      end
    end
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    reg_model.rain_window      = sfp_pkg::RAIN_WINDOW_RST;
    reg_model.rain_event_limit = sfp_pkg::RAIN_EVENT_LIMIT_RST;
    reg_model.tilt_threshold   = sfp_pkg::TILT_THRESHOLD_RST;
    reg_model.temp_limit       = sfp_pkg::TEMP_LIMIT_RST;
    reg_model.level_limit      = sfp_pkg::LEVEL_LIMIT_RST;
    win_cnt    = '0;
    evt_cnt    = '0;
    rain_flag  = 1'b0;
    last_level = '0;

    // accel, temp, echo, light, humid, typed, frame bytes, drives
    dir_tab[0]  = {16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0,
                   1'b1, 56'hF3_60_00_40_00_00_00, 4'b0111};
    dir_tab[1]  = {16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
                   1'b1, 56'hF3_1F_7F_5F_7F_08_69, 4'b1011};
    dir_tab[2]  = {16'h0100, 16'h07D0, 16'h003A, 1'b1, 1'b0,
                   1'b1, 56'hF3_20_10_40_7D_00_01, 4'b1101};
    // tilt exactly at threshold, temp one above limit, echo just below one level step
    dir_tab[3]  = {16'h00F0, 16'h07D1, 16'h0039, 1'b0, 1'b1, 1'b0, 56'h0, 4'h0};
    dir_tab[4]  = {16'h0100, 16'h8000, 16'hFFCA, 1'b1, 1'b0, 1'b0, 56'h0, 4'h0};
    dir_tab[5]  = {16'h8000, 16'h7FFF, 16'hFFC9, 1'b0, 1'b0, 1'b0, 56'h0, 4'h0};
    dir_tab[6]  = {16'h7FFF, 16'h0010, 16'h0073, 1'b1, 1'b1, 1'b0, 56'h0, 4'h0};
    dir_tab[7]  = {16'h0110, 16'h0800, 16'h0074, 1'b0, 1'b1, 1'b0, 56'h0, 4'h0};
    dir_tab[8]  = {16'h0800, 16'h0F00, 16'h1D00, 1'b1, 1'b0, 1'b0, 56'h0, 4'h0};
    dir_tab[9]  = {16'h07F0, 16'hF000, 16'h1CFF, 1'b0, 1'b0, 1'b0, 56'h0, 4'h0};
    dir_tab[10] = {16'hAAAA, 16'h5555, 16'h5555, 1'b1, 1'b1, 1'b0, 56'h0, 4'h0};
    dir_tab[11] = {16'h5555, 16'hAAAA, 16'hAAAA, 1'b0, 1'b0, 1'b0, 56'h0, 4'h0};
    dir_tab[12] = {16'h000F, 16'h000F, 16'h0001, 1'b1, 1'b0, 1'b0, 56'h0, 4'h0};
    // previous level at the valve limit, then one above, then the drive follows
    dir_tab[13] = {16'h1230, 16'h0300, 16'h0366, 1'b0, 1'b1, 1'b0, 56'h0, 4'h0};
    dir_tab[14] = {16'h4560, 16'h0700, 16'h03A0, 1'b1, 1'b1, 1'b0, 56'h0, 4'h0};
    dir_tab[15] = {16'h0000, 16'h07CF, 16'h0000, 1'b0, 1'b1, 1'b0, 56'h0, 4'h0};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_batch(NUM_DIR, 1'b1, 1'b0);
    wait_drained();

    program_regs(16'd3, 16'd1, 7'd15, 16'h8000, 11'd100);
    run_batch(110, 1'b0, 1'b1);
    wait_drained();

    program_regs(16'd0, 16'd0, 7'd0, 16'd0, 11'd0);
    run_batch(80, 1'b0, 1'b0);
    wait_drained();

    program_regs(16'd7, 16'hFFFF, 7'h7F, 16'hFFFF, 11'h7FF);
    run_batch(70, 1'b0, 1'b0);
    wait_drained();

    program_regs(16'($urandom_range(1, 40)), 16'($urandom_range(0, 20)),
                 7'($urandom), 16'($urandom), 11'($urandom));
    run_batch(100, 1'b0, 1'b1);
    wait_drained();

    // back-to-back burst, every item a tilt event: the window closes as raining
    program_regs(16'd20, 16'd15, 7'd0, 16'd2000, 11'd15);
    rx_free  = 1'b1;
    long_run = 1'b1;
    run_batch(34, 1'b0, 1'b0);
    wait_drained();
    rx_free  = 1'b0;
    long_run = 1'b0;

    // window of zero with a high limit: the next verdict clears raining
    program_regs(16'd0, 16'hFFFE, 7'd0, 16'd2000, 11'd15);
    run_batch(20, 1'b0, 1'b0);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mism_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
sv/sfp_pkg.sv
sv/sfp_front.sv
sv/sfp_fifo.sv
sv/sfp_back.sv
sv/sensor_frame_packer_with_rain_detect.sv
verif/sensor_frame_packer_with_rain_detect_tb.sv
